>>> sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, codes and defaults for the k-way sorted merge core.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_PUSHED = 3'd0;
    localparam logic [2:0] ST_POPPED = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         list_index;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [2:0]         status;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_REJECT,
        OP_POP,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [2:0]         list_index;
        logic signed [31:0] push_value;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } enq_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

`default_nettype wire

>>> sv/kwm_front.sv
// ----------------------------------------------------------------------------
// kwm_front
// Command acceptance and decoding into operations for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front #(
    parameter int NUM_LISTS = kwm_pkg::NUM_LISTS_DEF
) (
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire kwm_pkg::cmd_t cmd,
    input  wire logic          q_full,
    output kwm_pkg::enq_t      enq
);

    logic      index_ok;
    kwm_pkg::op_t op;

    assign index_ok = 32'(cmd.list_index) < 32'(NUM_LISTS);

    always_comb
    begin
        unique case (cmd.command)
            kwm_pkg::CMD_PUSH:  op = index_ok ? kwm_pkg::OP_PUSH : kwm_pkg::OP_REJECT;
            kwm_pkg::CMD_POP:   op = kwm_pkg::OP_POP;
            kwm_pkg::CMD_CLEAR: op = kwm_pkg::OP_CLEAR;
            default:            op = kwm_pkg::OP_NONE;
        endcase
    end

    assign cmd_stall             = q_full;
    assign enq.push              = cmd_valid && !q_full;
    assign enq.entry.op          = op;
    assign enq.entry.list_index  = cmd.list_index;
    assign enq.entry.push_value  = cmd.push_value;

endmodule

`default_nettype wire

>>> sv/kwm_queue.sv
// ----------------------------------------------------------------------------
// kwm_queue
// Short operation queue between the decoding and execution sides.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kwm_pkg::enq_t enq,
    input  wire logic          deq,
    output logic               q_full,
    output kwm_pkg::head_t     head
);

    localparam int QPTR_W = (kwm_pkg::QUEUE_DEPTH > 1) ? $clog2(kwm_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(kwm_pkg::QUEUE_DEPTH + 1);

    kwm_pkg::entry_t    slots_reg [kwm_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_deq;

    assign q_full     = count_reg == QCNT_W'(kwm_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = slots_reg[rd_ptr_reg];
    assign do_deq     = deq && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (enq.push && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_deq && !enq.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq.push)
        begin
            slots_reg[wr_ptr_reg] <= enq.entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/kwm_back.sv
// ----------------------------------------------------------------------------
// kwm_back
// Execution side: list storage, pointer bookkeeping, minimum scan and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_back #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kwm_pkg::head_t head,
    output logic                deq,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output kwm_pkg::rsp_t       rsp
);

    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int SPAN      = 2 * LIST_DEPTH;
    localparam int PTR_W     = $clog2(SPAN);
    localparam int SLOT_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int TOT_W     = $clog2(MEM_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [LIST_W-1:0]   cur_reg, cur_next;
    logic signed [31:0]  val_reg, val_next;
    logic                found_reg, found_next;
    logic [LIST_W-1:0]   best_list_reg, best_list_next;
    logic signed [31:0]  best_val_reg, best_val_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [LIST_W-1:0]   cmp_list_reg, cmp_list_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    kwm_pkg::rsp_t       res_reg, res_next;
    kwm_pkg::rsp_t       rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [PTR_W-1:0]    wr_ptr_reg [NUM_LISTS];
    logic [PTR_W-1:0]    rd_ptr_reg [NUM_LISTS];
    logic                pushed_reg [NUM_LISTS];
    logic signed [31:0]  last_pushed_reg [NUM_LISTS];

    logic signed [31:0]  mem [MEM_DEPTH];
    logic signed [31:0]  rd_data_reg;

    logic [PTR_W-1:0]    cur_wr;
    logic [PTR_W-1:0]    cur_rd;
    logic [PTR_W:0]      fill;
    logic                list_full;
    logic                head_valid;
    logic [PTR_W-1:0]    slot_ptr;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_re;
    logic                do_push;
    logic                do_pop;
    logic                do_clear;
    logic                take;

    assign cur_wr     = wr_ptr_reg[cur_reg];
    assign cur_rd     = rd_ptr_reg[cur_reg];
    assign fill       = (cur_wr >= cur_rd) ? ({1'b0, cur_wr} - {1'b0, cur_rd})
                        : ({1'b0, cur_wr} + (PTR_W+1)'(SPAN) - {1'b0, cur_rd});
    assign list_full  = fill >= (PTR_W+1)'(LIST_DEPTH);
    assign head_valid = cur_wr != cur_rd;
    assign slot_ptr   = do_push ? cur_wr : cur_rd;
    assign slot       = (slot_ptr >= PTR_W'(LIST_DEPTH)) ? SLOT_W'(slot_ptr - PTR_W'(LIST_DEPTH))
                                                        : SLOT_W'(slot_ptr);
    assign mem_addr   = ADDR_W'(cur_reg) * ADDR_W'(LIST_DEPTH) + ADDR_W'(slot);
    assign take       = cmp_valid_reg && (!found_reg || (rd_data_reg < best_val_reg));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        val_next       = val_reg;
        found_next     = found_reg;
        best_list_next = best_list_reg;
        best_val_next  = best_val_reg;
        cmp_valid_next = 1'b0;
        cmp_list_next  = cur_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        deq            = 1'b0;
        mem_re         = 1'b0;
        do_push        = 1'b0;
        do_pop         = 1'b0;
        do_clear       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    deq      = 1'b1;
                    res_next = '{merged_value: '0, status: kwm_pkg::ST_EMPTY, last: 1'b0};
                    unique case (head.entry.op)
                        kwm_pkg::OP_PUSH:
                        begin
                            cur_next   = LIST_W'(head.entry.list_index);
                            val_next   = head.entry.push_value;
                            state_next = S_PUSH;
                        end
                        kwm_pkg::OP_REJECT:
                        begin
                            res_next.status = kwm_pkg::ST_FULL;
                            state_next      = S_RESULT;
                        end
                        kwm_pkg::OP_POP:
                        begin
                            cur_next   = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        kwm_pkg::OP_CLEAR:
                        begin
                            do_clear   = 1'b1;
                            total_next = '0;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                res_next = '{merged_value: '0, status: kwm_pkg::ST_PUSHED, last: 1'b0};
                if (list_full)
                begin
                    res_next.status = kwm_pkg::ST_FULL;
                end
                else if (pushed_reg[cur_reg] && (val_reg < last_pushed_reg[cur_reg]))
                begin
                    res_next.status = kwm_pkg::ST_ORDER;
                end
                else
                begin
                    do_push    = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                mem_re         = head_valid;
                cmp_valid_next = head_valid;
                cmp_list_next  = cur_reg;
                if (take)
                begin
                    found_next     = 1'b1;
                    best_list_next = cmp_list_reg;
                    best_val_next  = rd_data_reg;
                end
                if (cur_reg == LIST_W'(NUM_LISTS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    best_list_next = cmp_list_reg;
                    best_val_next  = rd_data_reg;
                end
                if (found_reg || cmp_valid_reg)
                begin
                    cur_next   = take ? cmp_list_reg : best_list_reg;
                    state_next = S_COMMIT;
                end
                else
                begin
                    res_next   = '{merged_value: '0, status: kwm_pkg::ST_EMPTY, last: 1'b0};
                    state_next = S_RESULT;
                end
            end
            S_COMMIT:
            begin
                do_pop     = 1'b1;
                total_next = total_reg - 1'b1;
                res_next   = '{merged_value: best_val_reg, status: kwm_pkg::ST_POPPED,
                               last: total_reg == TOT_W'(1)};
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            val_reg       <= '0;
            found_reg     <= 1'b0;
            best_list_reg <= '0;
            best_val_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_list_reg  <= '0;
            total_reg     <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            val_reg       <= val_next;
            found_reg     <= found_next;
            best_list_reg <= best_list_next;
            best_val_reg  <= best_val_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_list_reg  <= cmp_list_next;
            total_reg     <= total_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                pushed_reg[i] <= 1'b0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                pushed_reg[i] <= 1'b0;
            end
        end
        else if (do_push)
        begin
            wr_ptr_reg[cur_reg] <= (cur_wr == PTR_W'(SPAN - 1)) ? '0 : cur_wr + 1'b1;
            pushed_reg[cur_reg] <= 1'b1;
        end
        else if (do_pop)
        begin
            rd_ptr_reg[cur_reg] <= (cur_rd == PTR_W'(SPAN - 1)) ? '0 : cur_rd + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            last_pushed_reg[cur_reg] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[mem_addr] <= val_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOT_W'(MEM_DEPTH))
        else $error("Stored value count exceeds capacity.");

    a_non_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != kwm_pkg::ST_POPPED))
        |-> ((rsp_reg.merged_value == 0) && !rsp_reg.last))
        else $error("Non-pop response carries a value or last flag.");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (head_valid && (total_reg != '0)))
        else $error("Pop committed on an empty list.");

    a_idle_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && head.valid) |=> (state_reg != S_IDLE))
        else $error("Dequeued operation was not started.");

endmodule

`default_nettype wire

>>> sv/k_way_sorted_merge_core.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// Merge engine for up to NUM_LISTS nondecreasing lists of signed words.
//
// Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and each
// gives exactly one response word on the rsp channel (rsp_valid, rsp_stall,
// rsp). A word moves when valid is high and stall is low at a clock edge.
// Commands are decoded into a two-entry queue, so up to two words are taken
// while the execution side is busy or a response is held. A word accepted
// into an empty queue reaches the queue head in the following cycle.
// A push checks the list for room and for order before it is written; a
// clear, a rejected push or a spare command code goes straight to the
// response register. In a pop the list heads are read from the single-port
// list memory one per cycle and compared by one signed comparator, then the
// winning list pointer advances; if every list is empty, none advances.
// Commands are executed one at a time, in order.
// Reset empties every list and the queue; the list memory itself is not
// cleared, since an entry is read only after it was written.
// While rsp_stall is high the response is held and the next finished
// response waits in the execution side until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_core #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire kwm_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output kwm_pkg::rsp_t      rsp
);

    kwm_pkg::enq_t  enq;
    kwm_pkg::head_t head;
    logic           q_full;
    logic           deq;

    kwm_front #(
        .NUM_LISTS (NUM_LISTS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .enq       (enq)
    );

    kwm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .enq    (enq),
        .deq    (deq),
        .q_full (q_full),
        .head   (head)
    );

    kwm_back #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .deq       (deq),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
